FILE: hw/rtl/rcc_pkg.sv
// Shared types and constants for the ROM check block.
// Holds the CRC-16 byte update, the segment window and the stage structs.
// No dependencies.
package rcc_pkg;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] CRC_SEG_LO = 16'hD000;
	localparam logic [15:0] CRC_SEG_HI = 16'hF000;
	localparam logic [7:0]  SUM_INIT   = 8'h00;

	// One registered input beat
	typedef struct packed {
		logic        valid;
		logic [7:0]  data_byte;
		logic        first;
		logic        last;
		logic [15:0] segment;
	} beat_s1_t;

	// One result beat
	typedef struct packed {
		logic [15:0] check_value;
		logic        passed;
		logic        used_crc;
	} result_t;

	// Advance the CRC by one byte, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	// True when the segment selects the CRC method
	function automatic logic seg_uses_crc(input logic [15:0] seg);
		return (seg >= CRC_SEG_LO) && (seg < CRC_SEG_HI);
	endfunction

endpackage

FILE: hw/rtl/rcc_in_if.sv
// Input channel of the ROM check block: one byte beat with run markers.
// No dependencies.
interface rcc_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first;
	logic        last;
	logic [15:0] segment;

	modport source (output valid, output data_byte, output first, output last,
		output segment, input ready);
	modport sink (input valid, input data_byte, input first, input last,
		input segment, output ready);
endinterface

FILE: hw/rtl/rcc_out_if.sv
// Output channel of the ROM check block: one result beat per run.
// No dependencies.
interface rcc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] check_value;
	logic        passed;
	logic        used_crc;

	modport source (output valid, output check_value, output passed, output used_crc,
		input ready);
	modport sink (input valid, input check_value, input passed, input used_crc,
		output ready);
endinterface

FILE: hw/rtl/rom_crc16_or_sum_check.sv
// Top level of the ROM check block: CRC-16 or byte sum over a byte stream.
// Depends on rcc_pkg, rcc_in_if, rcc_out_if, rcc_in_stage and rcc_accum.
//
//  channel  dir  payload                              beats
//  item     in   data_byte[8] first last segment[16]  one per ROM byte
//  result   out  check_value[16] passed used_crc      one per byte marked last
//
// One byte per cycle sustained while the result is not stalled; a result is
// valid in the cycle after the edge that moves its last byte from the input
// register into the result register.
// The CRC update is one byte-wide XOR network between the two registers.
// Reset sets the CRC to 0xFFFF, the sum to zero and selects the byte sum.
// A stalled result holds the pipeline; the input stage still takes a beat when
// it is empty.
module rom_crc16_or_sum_check (
	input logic     clk,
	input logic     arst_n,
	rcc_in_if.sink  item,
	rcc_out_if.source result
);

	rcc_pkg::beat_s1_t beat_s1;
	rcc_pkg::result_t  res;
	logic              advance;

	rcc_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.data_byte (item.data_byte),
		.first     (item.first),
		.last      (item.last),
		.segment   (item.segment),
		.advance   (advance),
		.beat_s1   (beat_s1)
	);

	rcc_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_s1   (beat_s1),
		.advance   (advance),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.result    (res)
	);

	assign result.check_value = res.check_value;
	assign result.passed      = res.passed;
	assign result.used_crc    = res.used_crc;

endmodule

FILE: hw/rtl/rcc_in_stage.sv
// Input register stage of the ROM check block.
// Depends on rcc_pkg.
module rcc_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               first,
	input  logic               last,
	input  logic [15:0]        segment,
	input  logic               advance,
	output rcc_pkg::beat_s1_t  beat_s1
);

	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic        first_s1;
	logic        last_s1;
	logic [15:0] segment_s1;

	// Take a new beat when the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold payload until the next accepted beat
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_byte_s1 <= data_byte;
			first_s1     <= first;
			last_s1      <= last;
			segment_s1   <= segment;
		end
	end

	assign beat_s1 = '{valid: valid_s1, data_byte: data_byte_s1, first: first_s1,
		last: last_s1, segment: segment_s1};

endmodule

FILE: hw/rtl/rcc_accum.sv
// Accumulators and result register of the ROM check block.
// Depends on rcc_pkg.
module rcc_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  rcc_pkg::beat_s1_t  beat_s1,
	output logic               advance,
	output logic               out_valid,
	input  logic               out_ready,
	output rcc_pkg::result_t   result
);

	logic [15:0]      crc_q;
	logic [7:0]       sum_q;
	logic             crc_sel_q;
	logic             out_valid_q;
	rcc_pkg::result_t result_q;

	logic [15:0] crc_base;
	logic [7:0]  sum_base;
	logic        sel;
	logic [15:0] crc_next;
	logic [7:0]  sum_next;
	logic [15:0] value;
	logic        fire;

	// Move the stage on when the result slot is free or being emptied
	assign advance = !out_valid_q || out_ready;
	assign fire    = beat_s1.valid && advance;

	// Restart on first, then fold in the byte
	always_comb begin
		crc_base = beat_s1.first ? rcc_pkg::CRC_INIT : crc_q;
		sum_base = beat_s1.first ? rcc_pkg::SUM_INIT : sum_q;
		sel      = beat_s1.first ? rcc_pkg::seg_uses_crc(beat_s1.segment) : crc_sel_q;
		crc_next = rcc_pkg::crc_byte(crc_base, beat_s1.data_byte);
		sum_next = sum_base + beat_s1.data_byte;
		value    = sel ? crc_next : {8'h00, sum_next};
	end

	// Update accumulators; drop back to initial values after a last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= rcc_pkg::CRC_INIT;
			sum_q     <= rcc_pkg::SUM_INIT;
			crc_sel_q <= 1'b0;
		end else if (fire) begin
			crc_sel_q <= sel;
			if (beat_s1.last) begin
				crc_q <= rcc_pkg::CRC_INIT;
				sum_q <= rcc_pkg::SUM_INIT;
			end else begin
				crc_q <= crc_next;
				sum_q <= sum_next;
			end
		end
	end

	// Result valid: load on a last byte, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && beat_s1.last;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire && beat_s1.last) begin
			result_q <= '{check_value: value, passed: (value == 16'h0000), used_crc: sel};
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule
